@@ design/rv32i_execute_branch_unit_top_assert.svh @@
// Assertion macros used by the execute/branch unit checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RV32I_EXECUTE_BRANCH_UNIT_TOP_ASSERT_SVH
`define RV32I_EXECUTE_BRANCH_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define REBU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define REBU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define REBU_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/rebu_pkg.sv @@
// Package for the RV32I execute/branch unit: op classes, funct3 codes and payload types.
// No dependencies; used by the interfaces, the RTL modules and the checker.
package rebu_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [3:0] {
    OP_REG    = 4'd0,
    OP_IMM    = 4'd1,
    OP_LOAD   = 4'd2,
    OP_STORE  = 4'd3,
    OP_BRANCH = 4'd4,
    OP_JAL    = 4'd5,
    OP_JALR   = 4'd6,
    OP_LUI    = 4'd7,
    OP_AUIPC  = 4'd8,
    OP_BUBBLE = 4'd9
  } op_t;

  // funct3 codes of the ALU operations
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes of the branch compares
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  typedef struct packed {
    logic [3:0]             op;
    logic [2:0]             funct3;
    logic                   alt;
    logic [XLEN-1:0]        pc;
    logic [XLEN-1:0]        src_a;
    logic [XLEN-1:0]        src_b;
    logic signed [XLEN-1:0] immediate;
    logic [XLEN-1:0]        pred_pc;
  } issue_t;

  typedef struct packed {
    logic [XLEN-1:0] alu_result;
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic            mispredict;
  } result_t;

endpackage

@@ design/rebu_chan_if.sv @@
// Valid/ready channel interfaces for the execute/branch unit.
// Depends on rebu_pkg for the payload types.
interface rebu_issue_if;
  import rebu_pkg::*;
  logic   valid;
  logic   ready;
  issue_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rebu_result_if;
  import rebu_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rebu_issue_stage.sv @@
// Input register of the execute/branch unit.
// Depends on rebu_pkg and rebu_issue_if.
module rebu_issue_stage (
  input  logic             clk,
  input  logic             rst,
  rebu_issue_if.sink       issue,
  input  logic             take,
  output logic             valid,
  output rebu_pkg::issue_t data
);
  import rebu_pkg::*;

  // Free slot, or the held item moves on this cycle.
  assign issue.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (issue.ready) begin
      valid <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid && issue.ready) begin
      data <= issue.data;
    end
  end

endmodule

@@ design/rebu_exec.sv @@
// Combinational ALU, branch compare and next-pc resolution.
// Depends on rebu_pkg.
module rebu_exec (
  input  rebu_pkg::issue_t  item,
  output rebu_pkg::result_t res
);
  import rebu_pkg::*;

  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  logic            is_reg;
  logic            do_sub;
  logic [XLEN-1:0] opnd_b;
  logic [4:0]      shamt;
  logic [XLEN-1:0] alu_sum;
  logic            lt_s;
  logic            lt_u;
  logic            br_lt_s;
  logic            br_lt_u;
  logic [XLEN-1:0] alu_val;
  logic            cond;
  logic [XLEN-1:0] link;
  logic [XLEN-1:0] target;
  logic [XLEN-1:0] addr;
  logic [XLEN-1:0] upper;

  assign is_reg  = (item.op == OP_REG);
  assign do_sub  = is_reg && item.alt && (item.funct3 == F3_ADD);
  assign opnd_b  = is_reg ? item.src_b : item.immediate;
  assign shamt   = opnd_b[4:0];
  assign alu_sum = item.src_a + (do_sub ? ~opnd_b : opnd_b) + XLEN'(do_sub);
  assign lt_s    = $signed(item.src_a) < $signed(opnd_b);
  assign lt_u    = item.src_a < opnd_b;
  assign br_lt_s = $signed(item.src_a) < $signed(item.src_b);
  assign br_lt_u = item.src_a < item.src_b;
  assign link    = item.pc + PC_STEP;
  assign target  = item.pc + item.immediate;
  assign addr    = item.src_a + item.immediate;
  assign upper   = item.immediate << 12;

  always_comb begin
    unique case (item.funct3)
      F3_ADD:  alu_val = alu_sum;
      F3_SLL:  alu_val = item.src_a << shamt;
      F3_SLT:  alu_val = XLEN'(lt_s);
      F3_SLTU: alu_val = XLEN'(lt_u);
      F3_XOR:  alu_val = item.src_a ^ opnd_b;
      F3_SR:   alu_val = item.alt ? XLEN'($signed(item.src_a) >>> shamt)
                                  : item.src_a >> shamt;
      F3_OR:   alu_val = item.src_a | opnd_b;
      F3_AND:  alu_val = item.src_a & opnd_b;
      default: alu_val = '0;
    endcase
  end

  always_comb begin
    unique case (item.funct3)
      BR_EQ:   cond = (item.src_a == item.src_b);
      BR_NE:   cond = (item.src_a != item.src_b);
      BR_LT:   cond = br_lt_s;
      BR_GE:   cond = !br_lt_s;
      BR_LTU:  cond = br_lt_u;
      BR_GEU:  cond = !br_lt_u;
      default: cond = 1'b0;  // funct3 2 and 3 never branch
    endcase
  end

  always_comb begin
    logic live;
    live           = 1'b1;
    res.alu_result = '0;
    res.next_pc    = link;
    res.taken      = 1'b0;
    unique case (item.op)
      OP_REG, OP_IMM:    res.alu_result = alu_val;
      OP_LOAD, OP_STORE: res.alu_result = addr;
      OP_BRANCH: begin
        if (cond) begin
          res.taken   = 1'b1;
          res.next_pc = target;
        end
      end
      OP_JAL: begin
        res.alu_result = link;
        res.next_pc    = target;
      end
      OP_JALR: begin
        res.alu_result = link;
        res.next_pc    = {addr[XLEN-1:1], 1'b0};
      end
      OP_LUI:   res.alu_result = upper;
      OP_AUIPC: res.alu_result = item.pc + upper;
      default:  live = 1'b0;  // bubble and unused classes
    endcase
    res.mispredict = live && (item.pred_pc != res.next_pc);
  end

endmodule

@@ design/rebu_result_stage.sv @@
// Result register of the execute/branch unit; drives the output channel.
// Depends on rebu_pkg and rebu_result_if.
module rebu_result_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rebu_pkg::result_t in_data,
  output logic              take,
  rebu_result_if.source     result
);
  import rebu_pkg::*;

  // Load a new result when empty or when the held one transfers now.
  assign take = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      result.data <= in_data;
    end
  end

endmodule

@@ design/rv32i_execute_branch_unit_top.sv @@
// Top level of the RV32I execute/branch unit.
// Depends on rebu_pkg, the channel interfaces, rebu_issue_stage, rebu_exec and
// rebu_result_stage.
//
//   channel  dir  payload                                            transfer
//   issue    in   op funct3 alt pc src_a src_b immediate pred_pc     valid & ready
//   result   out  alu_result next_pc taken mispredict                valid & ready
//
// An issue transfer loads the input register; the rebu_exec output is then
// captured by the result register. Throughput is one instruction per cycle while
// result.ready holds, set by the single pass through rebu_exec between them.
// Reset (rst, synchronous) empties both registers; payload is not cleared.
// With the result held, one more instruction is still taken into the input
// register; issue.ready drops only when both registers are full.
module rv32i_execute_branch_unit_top (
  input  logic          clk,
  input  logic          rst,
  rebu_issue_if.sink    issue,
  rebu_result_if.source result
);
  import rebu_pkg::*;

  logic    s1_valid;
  issue_t  s1_data;
  result_t s1_res;
  logic    take;

  // Input register
  rebu_issue_stage u_issue (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .take  (take),
    .valid (s1_valid),
    .data  (s1_data)
  );

  // ALU, branch compare, next pc and mispredict
  rebu_exec u_exec (
    .item (s1_data),
    .res  (s1_res)
  );

  // Result register
  rebu_result_stage u_result (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_data  (s1_res),
    .take     (take),
    .result   (result)
  );

endmodule

@@ design/rebu_checker.sv @@
// Port-level checker for the execute/branch unit, bound to the top level.
// Depends on rebu_pkg and rv32i_execute_branch_unit_top_assert.svh.
`include "rv32i_execute_branch_unit_top_assert.svh"

module rebu_checker (
  input logic              clk,
  input logic              rst,
  input logic              issue_ready,
  input logic              result_valid,
  input logic              result_ready,
  input rebu_pkg::result_t result_data
);
  import rebu_pkg::*;

  `REBU_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !result_valid, "result valid after reset")

  `REBU_ASSERT_IMP(a_ready_when_empty, clk, rst, !result_valid, issue_ready, "issue stalled with empty result")

  `REBU_ASSERT_IMP(a_branch_zero, clk, rst, result_valid && result_data.taken, result_data.alu_result == '0, "taken branch with nonzero result")

  `REBU_ASSERT_NXT(a_stall_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result changed")

endmodule

bind rv32i_execute_branch_unit_top rebu_checker u_rebu_checker (
  .clk          (clk),
  .rst          (rst),
  .issue_ready  (issue.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
